// File: rtl/file_transfer_frame_checker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame checker
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FILE_TRANSFER_FRAME_CHECKER_ASSERT_SVH
`define FILE_TRANSFER_FRAME_CHECKER_ASSERT_SVH

// Checks that an expression holds at every clock edge out of reset.
`define FTFC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("frame checker invariant violated");

// Checks that a condition implies another in the same cycle.
`define FTFC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker implication violated");

`endif

// File: rtl/ftfc_pkg.sv
// ----------------------------------------------------------------------------
// Frame checker package
// Types, constants and helper functions shared by the frame checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftfc_pkg;

  localparam int POSITION_BITS = 32;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam int SIZE_BITS = 64;
  localparam int SIG_LEN = 6;
  localparam int VERSION_POS = 6;
  localparam int TYPE_POS = 7;
  localparam int HEADER_LEN = 16;
  localparam int TRAILER_LEN = 4;
  localparam int MIN_LEN = 20;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SIGNATURE = 3'd1,
    STATUS_VERSION   = 3'd2,
    STATUS_CRC       = 3'd3,
    STATUS_TYPE      = 3'd4,
    STATUS_SIZE      = 3'd5
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_EXPECTED_VERSION = 2'd0,
    CFG_REQUEST_TYPE     = 2'd1,
    CFG_OFFER_TYPE       = 2'd2,
    CFG_TYPE_LIMIT       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] expected_version;
    logic [7:0] request_type_code;
    logic [7:0] offer_type_code;
    logic [7:0] type_limit;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       eom;
  } result_t;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h49;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4B;
      3'd3: v = 8'h46;
      3'd4: v = 8'h54;
      3'd5: v = 8'h50;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ftfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Frame checker configuration registers
// Holds the expected version, type codes and type limit set over the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftfc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ftfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                          cfg_data,
  output ftfc_pkg::cfg_t                      cfg
);
  import ftfc_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_version  <= 8'd1;
      regs.request_type_code <= 8'd0;
      regs.offer_type_code   <= 8'd1;
      regs.type_limit        <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_EXPECTED_VERSION: regs.expected_version <= cfg_data;
        CFG_REQUEST_TYPE:     regs.request_type_code <= cfg_data;
        CFG_OFFER_TYPE:       regs.offer_type_code <= cfg_data;
        CFG_TYPE_LIMIT:       regs.type_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ftfc_parser.sv
// ----------------------------------------------------------------------------
// Frame checker parser
// Per-byte frame state: trailer delay line, CRC, header capture, payload tagging
// and the final status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftfc_parser (
  input  logic                clk,
  input  logic                rst,
  input  ftfc_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic [1:0]          push_n,
  output ftfc_pkg::result_t   res0,
  output ftfc_pkg::result_t   res1
);
  import ftfc_pkg::*;

  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [31:0]              crc_register, crc_register_next;
  logic [7:0]               hold_back_line [4];
  logic [7:0]               hold_back_line_next [4];
  logic [7:0]               header_type, header_type_next;
  logic [SIZE_BITS-1:0]     declared_size, declared_size_next;
  logic                     signature_ok, signature_ok_next;
  logic                     version_ok, version_ok_next;
  logic                     filename_done, filename_done_next;
  logic                     position_overflow, position_overflow_next;

  logic [POSITION_BITS-1:0] body_idx;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [1:0]               slot;
  logic [7:0]               leaving;
  logic                     is_offer, is_req;
  logic                     pay_v;
  kind_t                    pay_kind;
  logic [31:0]              rx;
  status_t                  st;

  assign body_idx = byte_position - POSITION_BITS'(TRAILER_LEN);
  assign pos_inc  = byte_position + 1'b1;
  assign slot     = byte_position[1:0];
  assign leaving  = hold_back_line[slot];
  assign is_offer = (header_type == cfg.offer_type_code);
  assign is_req   = (header_type == cfg.request_type_code);

  always_comb begin
    byte_position_next     = byte_position;
    crc_register_next      = crc_register;
    hold_back_line_next    = hold_back_line;
    header_type_next       = header_type;
    declared_size_next     = declared_size;
    signature_ok_next      = signature_ok;
    version_ok_next        = version_ok;
    filename_done_next     = filename_done;
    position_overflow_next = position_overflow;
    pay_v                  = 1'b0;
    pay_kind               = KIND_NAME;
    rx                     = '0;
    st                     = STATUS_OK;
    if (accept) begin
      if (position_overflow || (byte_position == POS_MAX)) begin
        position_overflow_next = 1'b1;
      end else begin
        if (byte_position >= POSITION_BITS'(TRAILER_LEN)) begin
          crc_register_next = crc_update(crc_register, leaving);
          if (body_idx < POSITION_BITS'(SIG_LEN)) begin
            if (leaving != sig_byte(body_idx[2:0])) begin
              signature_ok_next = 1'b0;
            end
          end else if (body_idx == POSITION_BITS'(VERSION_POS)) begin
            version_ok_next = (leaving == cfg.expected_version);
          end else if (body_idx == POSITION_BITS'(TYPE_POS)) begin
            header_type_next = leaving;
          end else if (body_idx < POSITION_BITS'(HEADER_LEN)) begin
            for (int l = 0; l < 8; l++) begin
              if (body_idx[2:0] == 3'(l)) begin
                declared_size_next[8*l +: 8] = declared_size[8*l +: 8] | leaving;
              end
            end
          end else if (is_offer || is_req) begin
            if (!filename_done) begin
              if (leaving == 8'd0) begin
                filename_done_next = 1'b1;
              end else begin
                pay_v    = 1'b1;
                pay_kind = KIND_NAME;
              end
            end else if (is_offer) begin
              pay_v    = 1'b1;
              pay_kind = KIND_DATA;
            end
          end
        end
        hold_back_line_next[slot] = in_byte;
        byte_position_next = pos_inc;
      end

      if (in_last) begin
        rx = {hold_back_line_next[slot], hold_back_line_next[slot + 2'd3],
              hold_back_line_next[slot + 2'd2], hold_back_line_next[slot + 2'd1]};
        if (position_overflow_next || (byte_position < POSITION_BITS'(MIN_LEN - 1))) begin
          st = STATUS_SIZE;
        end else if (!signature_ok_next) begin
          st = STATUS_SIGNATURE;
        end else if (!version_ok_next) begin
          st = STATUS_VERSION;
        end else if (rx != ~crc_register_next) begin
          st = STATUS_CRC;
        end else if (header_type_next >= cfg.type_limit) begin
          st = STATUS_TYPE;
        end else if (declared_size_next != SIZE_BITS'(pos_inc)) begin
          st = STATUS_SIZE;
        end else begin
          st = STATUS_OK;
        end
        byte_position_next     = '0;
        crc_register_next      = CRC_INIT;
        hold_back_line_next    = '{default: 8'd0};
        header_type_next       = 8'd0;
        declared_size_next     = '0;
        signature_ok_next      = 1'b1;
        version_ok_next        = 1'b0;
        filename_done_next     = 1'b0;
        position_overflow_next = 1'b0;
      end
    end
  end

  always_comb begin
    res1.kind   = KIND_STATUS;
    res1.data   = 8'd0;
    res1.status = st;
    res1.eom    = 1'b1;
    if (pay_v) begin
      res0.kind   = pay_kind;
      res0.data   = leaving;
      res0.status = STATUS_OK;
      res0.eom    = 1'b0;
    end else begin
      res0 = res1;
    end
    push_n = {1'b0, pay_v} + {1'b0, accept & in_last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      crc_register      <= CRC_INIT;
      hold_back_line    <= '{default: 8'd0};
      header_type       <= 8'd0;
      declared_size     <= '0;
      signature_ok      <= 1'b1;
      version_ok        <= 1'b0;
      filename_done     <= 1'b0;
      position_overflow <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      crc_register      <= crc_register_next;
      hold_back_line    <= hold_back_line_next;
      header_type       <= header_type_next;
      declared_size     <= declared_size_next;
      signature_ok      <= signature_ok_next;
      version_ok        <= version_ok_next;
      filename_done     <= filename_done_next;
      position_overflow <= position_overflow_next;
    end
  end

endmodule

// File: rtl/ftfc_result_fifo.sv
// ----------------------------------------------------------------------------
// Frame checker result queue
// Four-entry queue: up to two results in a cycle, one out unless out_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "file_transfer_frame_checker_assert.svh"

module ftfc_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  ftfc_pkg::result_t   res0,
  input  ftfc_pkg::result_t   res1,
  output logic                full_for_two,
  output logic                out_valid,
  input  logic                out_stall,
  output ftfc_pkg::result_t   head
);
  import ftfc_pkg::*;

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_BITS-1:0] rd_ptr, rd_ptr_next;
  logic [FIFO_CNT_BITS-1:0] count, count_next;
  logic                     pop;

  assign out_valid    = (count != '0);
  assign head         = mem[rd_ptr];
  assign pop          = out_valid && !out_stall;
  assign full_for_two = (count > FIFO_CNT_BITS'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_PTR_BITS'(push_n);
    rd_ptr_next = rd_ptr + FIFO_PTR_BITS'(pop);
    count_next  = count + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  `FTFC_ASSERT_ALWAYS(a_count_bound, count <= FIFO_CNT_BITS'(FIFO_DEPTH))
  `FTFC_ASSERT_IMPLIES(a_no_push_when_full, push_n != 2'd0, !full_for_two)
  `FTFC_ASSERT_IMPLIES(a_ptr_match, rd_ptr == wr_ptr, (count == '0) || (count == FIFO_CNT_BITS'(FIFO_DEPTH)))

endmodule

// File: rtl/file_transfer_frame_checker.sv
// ----------------------------------------------------------------------------
// File transfer frame checker
// Streams message bytes, tags filename and data bytes, and reports a status.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle and keeps that rate as long as
// the result side takes one result per cycle. Each byte is handled in the
// cycle it is accepted: the delay line releases the byte four places back,
// the byte-wise CRC-32 update and header capture act on it, and up to two
// results (a filename or data byte, and the status on the last byte) enter a
// four-entry result queue. Input stall is raised while fewer than two queue
// entries are free, so a last byte that also releases a payload byte pushes
// two results into the queue at once. The eight-step CRC update is the
// longest path. Filename and data bytes go out before the status is known;
// the status result closes each message.
`timescale 1ns / 1ps

module file_transfer_frame_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic [7:0]                          out_byte,
  output logic [2:0]                          status,
  output logic                                end_of_message,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ftfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                          cfg_data
);
  import ftfc_pkg::*;

  cfg_t       cfg;
  logic       accept;
  logic       full_for_two;
  logic [1:0] push_n;
  result_t    res0, res1, head;

  assign in_stall = full_for_two;
  assign accept   = in_valid && !in_stall;

  ftfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ftfc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push_n  (push_n),
    .res0    (res0),
    .res1    (res1)
  );

  ftfc_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_n       (push_n),
    .res0         (res0),
    .res1         (res1),
    .full_for_two (full_for_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .head         (head)
  );

  assign kind           = head.kind;
  assign out_byte       = head.data;
  assign status         = head.status;
  assign end_of_message = head.eom;

endmodule
